/* hdl/csbp_pkg.sv */
// Shared types and constants for the clipped sprite blit page packer.
`default_nettype none

package csbp_pkg;

  // Widest cursor column and row that reach the page store (256 columns, 64 rows).
  localparam int COL_W = 8;
  localparam int ROW_W = 6;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_BLIT  = 2'd0,
    OP_PIXEL = 2'd1,
    OP_FILL  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FILL  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             value;
    logic             done;
  } cmd_t;

endpackage

`default_nettype wire

/* hdl/csbp_front.sv */
// Front: accepts items, tracks the blit cursor and turns each item into a store command.
`default_nettype none

module csbp_front #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_ROWS    = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_operation,
  input  wire logic signed [8:0] in_origin_x,
  input  wire logic signed [8:0] in_origin_y,
  input  wire logic [7:0]        in_sprite_width,
  input  wire logic [7:0]        in_sprite_height,
  input  wire logic              in_pixel_value,
  input  wire logic [1:0]        in_page_index,
  input  wire logic [6:0]        in_column_index,
  input  wire logic              clearing,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output csbp_pkg::cmd_t         push_cmd
);
  import csbp_pkg::*;

  localparam int PAGE_COUNT = (SCREEN_ROWS + 7) / 8;
  localparam logic signed [9:0] COLS_S = 10'(SCREEN_COLUMNS);
  localparam logic signed [9:0] ROWS_S = 10'(SCREEN_ROWS);

  logic signed [9:0] cursor_row_r, cursor_row_nxt;
  logic signed [9:0] cursor_col_r, cursor_col_nxt;
  logic signed [9:0] blit_left_r, blit_left_nxt;
  logic signed [9:0] blit_right_end_r, blit_right_end_nxt;
  logic signed [9:0] blit_bottom_end_r, blit_bottom_end_nxt;
  logic              blit_active_r, blit_active_nxt;

  op_t               op;
  logic              accept;
  logic signed [9:0] org_x;
  logic signed [9:0] org_y;
  logic [8:0]        w_sat;
  logic [8:0]        h_sat;
  logic              on_screen;
  logic signed [9:0] col_inc;
  logic signed [9:0] row_inc;
  logic              read_ok;

  // Hold off items while the store is being cleared after reset
  assign in_ready   = push_ready && !clearing;
  assign push_valid = in_valid && !clearing;
  assign accept     = in_valid && in_ready;
  assign op         = op_t'(in_operation);

  // Saturate the sprite size and sign-extend the origin
  assign org_x = {in_origin_x[8], in_origin_x};
  assign org_y = {in_origin_y[8], in_origin_y};
  assign w_sat = (9'(in_sprite_width) > 9'(SCREEN_COLUMNS)) ? 9'(SCREEN_COLUMNS)
                                                           : 9'(in_sprite_width);
  assign h_sat = (9'(in_sprite_height) > 9'(SCREEN_ROWS)) ? 9'(SCREEN_ROWS)
                                                         : 9'(in_sprite_height);

  // Clip test and raster step for the cursor
  assign on_screen = (cursor_col_r >= 10'sd0) && (cursor_col_r < COLS_S) &&
                     (cursor_row_r >= 10'sd0) && (cursor_row_r < ROWS_S);
  assign col_inc   = cursor_col_r + 10'sd1;
  assign row_inc   = cursor_row_r + 10'sd1;
  assign read_ok   = (32'(in_page_index) < PAGE_COUNT) &&
                     (32'(in_column_index) < SCREEN_COLUMNS);

  // Classify the item and advance the blit state
  always_comb begin
    cursor_row_nxt      = cursor_row_r;
    cursor_col_nxt      = cursor_col_r;
    blit_left_nxt       = blit_left_r;
    blit_right_end_nxt  = blit_right_end_r;
    blit_bottom_end_nxt = blit_bottom_end_r;
    blit_active_nxt     = blit_active_r;
    push_cmd            = '0;
    push_cmd.kind       = CMD_NOP;
    push_cmd.value      = in_pixel_value;
    unique case (op)
      OP_BLIT: begin
        blit_left_nxt       = org_x;
        blit_right_end_nxt  = org_x + $signed({1'b0, w_sat});
        blit_bottom_end_nxt = org_y + $signed({1'b0, h_sat});
        cursor_col_nxt      = org_x;
        cursor_row_nxt      = org_y;
        blit_active_nxt     = (w_sat != 9'd0) && (h_sat != 9'd0);
      end
      OP_PIXEL: begin
        if (blit_active_r) begin
          if (on_screen) begin
            push_cmd.kind = CMD_WRITE;
            push_cmd.row  = cursor_row_r[ROW_W-1:0];
            push_cmd.col  = cursor_col_r[COL_W-1:0];
          end
          cursor_col_nxt = col_inc;
          if (col_inc >= blit_right_end_r) begin
            cursor_col_nxt = blit_left_r;
            cursor_row_nxt = row_inc;
            if (row_inc >= blit_bottom_end_r) begin
              blit_active_nxt = 1'b0;
              push_cmd.done   = 1'b1;
            end
          end
        end
      end
      OP_FILL: begin
        push_cmd.kind = CMD_FILL;
      end
      OP_READ: begin
        if (read_ok) begin
          push_cmd.kind = CMD_READ;
          push_cmd.row  = ROW_W'({in_page_index, 3'b000});
          push_cmd.col  = COL_W'(in_column_index);
        end
      end
      default: begin
        push_cmd.kind = CMD_NOP;
      end
    endcase
  end

  // Commit blit state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_row_r      <= '0;
      cursor_col_r      <= '0;
      blit_left_r       <= '0;
      blit_right_end_r  <= '0;
      blit_bottom_end_r <= '0;
      blit_active_r     <= 1'b0;
    end else if (accept) begin
      cursor_row_r      <= cursor_row_nxt;
      cursor_col_r      <= cursor_col_nxt;
      blit_left_r       <= blit_left_nxt;
      blit_right_end_r  <= blit_right_end_nxt;
      blit_bottom_end_r <= blit_bottom_end_nxt;
      blit_active_r     <= blit_active_nxt;
    end
  end

  // The last pixel of a sprite ends the blit
  a_done_ends_blit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && push_cmd.done) |=> !blit_active_r)
    else $error("blit still active after its last pixel");

  // A pixel with no blit active does nothing
  a_idle_pixel_nop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_PIXEL && !blit_active_r) |->
    (push_cmd.kind == CMD_NOP && !push_cmd.done))
    else $error("pixel outside a blit produced work");

  // An empty sprite never starts a blit
  a_empty_sprite: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_BLIT && (in_sprite_width == 8'd0 || in_sprite_height == 8'd0))
    |=> !blit_active_r)
    else $error("empty sprite started a blit");

endmodule

`default_nettype wire

/* hdl/csbp_queue.sv */
// Command queue between the front and the back.
`default_nettype none

module csbp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire csbp_pkg::cmd_t push_cmd,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output csbp_pkg::cmd_t      pop_cmd
);
  import csbp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and track occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/csbp_back.sv */
// Back: runs store commands against the page memory and drives the result register.
`default_nettype none

module csbp_back #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_ROWS    = 32
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire csbp_pkg::cmd_t cmd,
  output logic                clearing,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_packed_byte,
  output logic                out_pixel_written,
  output logic                out_blit_done
);
  import csbp_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_ROWS + 7) / 8;
  localparam int STORE_BYTES = PAGE_COUNT * SCREEN_COLUMNS;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CW          = $clog2(SCREEN_COLUMNS);
  localparam int PW          = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_MODIFY
  } state_t;

  // Bits of a page that belong to rows that exist
  function automatic logic [7:0] page_mask(input int page);
    int rows;
    begin
      rows = SCREEN_ROWS - page * 8;
      if (rows >= 8) begin
        page_mask = 8'hFF;
      end else if (rows <= 0) begin
        page_mask = 8'h00;
      end else begin
        page_mask = 8'((9'd1 << rows) - 9'd1);
      end
    end
  endfunction

  // Page-major byte address of a row and column
  function automatic logic [AW-1:0] byte_addr(input logic [ROW_W-1:0] row,
                                              input logic [COL_W-1:0] col);
    begin
      byte_addr = AW'(32'(row[ROW_W-1:3]) * SCREEN_COLUMNS + 32'(col));
    end
  endfunction

  logic [7:0] page_mem_r [STORE_BYTES];
  logic [7:0] rd_data_r;

  state_t        state_r, state_nxt;
  cmd_t          cmd_r, cmd_nxt;
  logic [AW-1:0] sweep_addr_r, sweep_addr_nxt;
  logic [CW-1:0] sweep_col_r, sweep_col_nxt;
  logic [PW-1:0] sweep_page_r, sweep_page_nxt;
  logic          sweep_clear_r, sweep_clear_nxt;
  logic          sweep_value_r, sweep_value_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_packed_r, out_packed_nxt;
  logic          out_written_r, out_written_nxt;
  logic          out_done_r, out_done_nxt;

  logic          out_free;
  logic          sweep_last;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    bit_mask;

  assign out_free   = !out_valid_r || out_ready;
  assign sweep_last = (sweep_addr_r == AW'(STORE_BYTES - 1));
  assign bit_mask   = 8'(9'd1 << cmd_r.row[2:0]);
  assign clearing   = (state_r == ST_SWEEP) && sweep_clear_r;

  assign out_valid         = out_valid_r;
  assign out_packed_byte   = out_packed_r;
  assign out_pixel_written = out_written_r;
  assign out_blit_done     = out_done_r;

  // Sequence commands and memory accesses
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    sweep_addr_nxt  = sweep_addr_r;
    sweep_col_nxt   = sweep_col_r;
    sweep_page_nxt  = sweep_page_r;
    sweep_clear_nxt = sweep_clear_r;
    sweep_value_nxt = sweep_value_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_packed_nxt  = out_packed_r;
    out_written_nxt = out_written_r;
    out_done_nxt    = out_done_r;
    cmd_ready       = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = '0;
    unique case (state_r)
      ST_SWEEP: begin
        // Write one byte per cycle; rewriting the last byte while stalled is harmless
        mem_we    = 1'b1;
        mem_waddr = sweep_addr_r;
        mem_wdata = sweep_value_r ? page_mask(int'(sweep_page_r)) : 8'h00;
        if (!sweep_last) begin
          sweep_addr_nxt = sweep_addr_r + 1'b1;
          if (sweep_col_r == CW'(SCREEN_COLUMNS - 1)) begin
            sweep_col_nxt  = '0;
            sweep_page_nxt = sweep_page_r + 1'b1;
          end else begin
            sweep_col_nxt = sweep_col_r + 1'b1;
          end
        end else if (sweep_clear_r) begin
          sweep_clear_nxt = 1'b0;
          state_nxt       = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_packed_nxt  = 8'h00;
          out_written_nxt = 1'b0;
          out_done_nxt    = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          cmd_nxt   = cmd;
          unique case (cmd.kind)
            CMD_NOP: begin
              out_valid_nxt   = 1'b1;
              out_packed_nxt  = 8'h00;
              out_written_nxt = 1'b0;
              out_done_nxt    = cmd.done;
            end
            CMD_WRITE: begin
              mem_re    = 1'b1;
              mem_raddr = byte_addr(cmd.row, cmd.col);
              state_nxt = ST_MODIFY;
            end
            CMD_READ: begin
              mem_re    = 1'b1;
              mem_raddr = byte_addr(cmd.row, cmd.col);
              state_nxt = ST_READ;
            end
            CMD_FILL: begin
              sweep_addr_nxt  = '0;
              sweep_col_nxt   = '0;
              sweep_page_nxt  = '0;
              sweep_clear_nxt = 1'b0;
              sweep_value_nxt = cmd.value;
              state_nxt       = ST_SWEEP;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_packed_nxt  = rd_data_r;
          out_written_nxt = 1'b0;
          out_done_nxt    = 1'b0;
          state_nxt       = ST_IDLE;
        end
      end
      ST_MODIFY: begin
        // Write back the fetched byte with the pixel's bit set or cleared
        if (out_free) begin
          mem_we          = 1'b1;
          mem_waddr       = byte_addr(cmd_r.row, cmd_r.col);
          mem_wdata       = cmd_r.value ? (rd_data_r | bit_mask) : (rd_data_r & ~bit_mask);
          out_valid_nxt   = 1'b1;
          out_packed_nxt  = 8'h00;
          out_written_nxt = 1'b1;
          out_done_nxt    = cmd_r.done;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and the result register; start with a clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SWEEP;
      sweep_addr_r  <= '0;
      sweep_col_r   <= '0;
      sweep_page_r  <= '0;
      sweep_clear_r <= 1'b1;
      sweep_value_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sweep_addr_r  <= sweep_addr_nxt;
      sweep_col_r   <= sweep_col_nxt;
      sweep_page_r  <= sweep_page_nxt;
      sweep_clear_r <= sweep_clear_nxt;
      sweep_value_r <= sweep_value_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    out_packed_r  <= out_packed_nxt;
    out_written_r <= out_written_nxt;
    out_done_r    <= out_done_nxt;
  end

  // Page memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= page_mem_r[mem_raddr];
    end
  end

  // No result leaves while the store is being cleared after reset
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid_r)
    else $error("result issued during the clearing sweep");

  // The write-back step always belongs to a pixel write
  a_modify_is_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MODIFY) |-> (cmd_r.kind == CMD_WRITE))
    else $error("write-back step without a pixel write");

  // The store is not written while waiting for work or for read data
  a_no_stray_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_READ) |-> !mem_we)
    else $error("page store written outside a sweep or write-back");

endmodule

`default_nettype wire

/* hdl/clipped_sprite_blit_page_packer_top.sv */
// Top level of the clipped sprite blit page packer.
//
// Keeps a SCREEN_COLUMNS x SCREEN_ROWS one-bit framebuffer in a page memory with one write
// port and one read port (one byte per column of each eight-row page, top row in bit 0) and
// gives one result beat per input beat, in order. Begin-blit, a pixel that is clipped or
// arrives with no blit active, and a read outside the screen are answered from the idle
// state without touching the store; a read that hits the store fetches its page byte and
// then returns it; an on-screen pixel reads its page byte and then writes it back.
// Fill writes one byte per cycle over all (SCREEN_ROWS+7)/8 * SCREEN_COLUMNS bytes (512 at
// the defaults), then delivers its result. After reset the memory is cleared by the same
// sweep, and in_ready stays low until it finishes. A two-entry command queue lets the input
// side keep accepting while the back end works or the result waits.
`default_nettype none

module clipped_sprite_blit_page_packer_top #(
  parameter int SCREEN_COLUMNS = 128,
  parameter int SCREEN_ROWS    = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_operation,
  input  wire logic signed [8:0] in_origin_x,
  input  wire logic signed [8:0] in_origin_y,
  input  wire logic [7:0]        in_sprite_width,
  input  wire logic [7:0]        in_sprite_height,
  input  wire logic              in_pixel_value,
  input  wire logic [1:0]        in_page_index,
  input  wire logic [6:0]        in_column_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_packed_byte,
  output logic                   out_pixel_written,
  output logic                   out_blit_done
);
  import csbp_pkg::*;

  logic clearing;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // Classify items and track the cursor
  csbp_front #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_sprite_width  (in_sprite_width),
    .in_sprite_height (in_sprite_height),
    .in_pixel_value   (in_pixel_value),
    .in_page_index    (in_page_index),
    .in_column_index  (in_column_index),
    .clearing         (clearing),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_cmd         (push_cmd)
  );

  // Decouple front and back
  csbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Execute against the page memory
  csbp_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (pop_valid),
    .cmd_ready         (pop_ready),
    .cmd               (pop_cmd),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_packed_byte   (out_packed_byte),
    .out_pixel_written (out_pixel_written),
    .out_blit_done     (out_blit_done)
  );

endmodule

`default_nettype wire
